// ===== src/fnu_pkg.sv =====
`timescale 1ns / 1ps
package fnu_pkg;

    localparam int LANES      = 3;
    localparam int COORD_W    = 16;
    localparam int NORM_W     = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam int MAG_W      = CROSS_W - 2;      // |c| <= 2*65535^2 < 2^33
    localparam int LO_W       = 17;
    localparam int HI_W       = MAG_W - LO_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int REM_W      = SUM_W + 1;
    localparam int QUO_W      = 31;               // quotient mag^2 * 2^30 / s
    localparam int DIV_STEPS  = QUO_W;
    localparam int ROOT_W     = 16;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int TRIAL_W    = QUO_W + 2;
    localparam int IN_DATA_W  = 9 * COORD_W;
    localparam int OUT_DATA_W = LANES * NORM_W;

    typedef logic [LANES-1:0][NORM_W-1:0] normal_t;

    typedef struct packed {
        normal_t normal;
        logic    degenerate;
    } result_t;

endpackage

// ===== src/face_normal_unit_top.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle while the skid register is empty; 7 front stages
// (differences, cross product, squares), 31 restoring divide stages and 16 square
// root stages, one step each.
// Output register plus skid register decouple m_tready from s_tready.
// Reset: synchronous on aresetn low; clears all valid bits, the datapath
// registers are not reset.
module face_normal_unit_top
    import fnu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y, third_z
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // normal_x, normal_y, normal_z
    output logic [OUT_DATA_W-1:0] m_tdata,
    // degenerate
    output logic                  m_tuser
);

    logic en;

    // front stages
    logic                                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic                                     v5_reg, v6_reg, v7_reg;
    logic signed [LANES-1:0][DIFF_W-1:0]      a_reg, a_next, b_reg, b_next;
    logic signed [5:0][PROD_W-1:0]            p_reg, p_next;
    logic signed [LANES-1:0][CROSS_W-1:0]     c_reg, c_next;
    logic [LANES-1:0][MAG_W-1:0]              mag_reg, mag_next;
    logic [LANES-1:0]                         sign4_reg, sign5_reg, sign6_reg, sign7_reg;
    logic [LANES-1:0][2*HI_W-1:0]             hh_reg, hh_next;
    logic [LANES-1:0][HI_W+LO_W-1:0]          hl_reg, hl_next;
    logic [LANES-1:0][2*LO_W-1:0]             ll_reg, ll_next;
    logic                                     deg5_reg, deg5_next, deg6_reg, deg7_reg;
    logic [LANES-1:0][SQ_W-1:0]               sq_reg, sq_next, sq7_reg;
    logic [SUM_W-1:0]                         s7_reg, s7_next;

    // divide stages
    logic [DIV_STEPS-1:0]                     dv_v_reg;
    logic [DIV_STEPS-1:0][LANES-1:0][REM_W-1:0] dv_r_reg, dv_r_next;
    logic [DIV_STEPS-1:0][LANES-1:0][QUO_W-1:0] dv_q_reg, dv_q_next;
    logic [DIV_STEPS-1:0][SUM_W-1:0]          dv_s_reg, dv_s_next;
    logic [DIV_STEPS-1:0][LANES-1:0]          dv_sign_reg, dv_sign_next;
    logic [DIV_STEPS-1:0]                     dv_deg_reg, dv_deg_next;

    // square root stages
    logic [SQRT_STEPS-1:0]                    sr_v_reg;
    logic [SQRT_STEPS-1:0][LANES-1:0][QUO_W-1:0]  sr_rem_reg, sr_rem_next;
    logic [SQRT_STEPS-1:0][LANES-1:0][ROOT_W-1:0] sr_root_reg, sr_root_next;
    logic [SQRT_STEPS-1:0][LANES-1:0]         sr_sign_reg, sr_sign_next;
    logic [SQRT_STEPS-1:0]                    sr_deg_reg, sr_deg_next;

    // final stage and output
    logic                                     fin_v_reg;
    result_t                                  fin_reg, fin_next;
    logic                                     out_v_reg, out_v_next, skid_v_reg, skid_v_next;
    result_t                                  out_reg, out_next, skid_reg, skid_next;

    assign en       = !skid_v_reg;
    assign s_tready = en;

    // ---------------- front datapath ----------------
    always_comb begin
        logic signed [LANES-1:0][DIFF_W-1:0] v1, v2, v3;
        logic [LANES-1:0][HI_W-1:0]          h;
        logic [LANES-1:0][LO_W-1:0]          l;
        for (int i = 0; i < LANES; i++) begin
            v1[i] = DIFF_W'($signed(s_tdata[i*COORD_W +: COORD_W]));
            v2[i] = DIFF_W'($signed(s_tdata[(i+3)*COORD_W +: COORD_W]));
            v3[i] = DIFF_W'($signed(s_tdata[(i+6)*COORD_W +: COORD_W]));
            a_next[i] = v3[i] - v2[i];
            b_next[i] = v2[i] - v1[i];
        end
        // ay*bz, by*az, az*bx, ax*bz, ax*by, bx*ay; packed elements select unsigned
        p_next[0] = $signed(a_reg[1]) * $signed(b_reg[2]);
        p_next[1] = $signed(b_reg[1]) * $signed(a_reg[2]);
        p_next[2] = $signed(a_reg[2]) * $signed(b_reg[0]);
        p_next[3] = $signed(a_reg[0]) * $signed(b_reg[2]);
        p_next[4] = $signed(a_reg[0]) * $signed(b_reg[1]);
        p_next[5] = $signed(b_reg[0]) * $signed(a_reg[1]);
        for (int i = 0; i < LANES; i++) begin
            c_next[i] = CROSS_W'($signed(p_reg[2*i])) - CROSS_W'($signed(p_reg[2*i+1]));
        end
        for (int i = 0; i < LANES; i++) begin
            mag_next[i] = c_reg[i][CROSS_W-1] ? MAG_W'(-c_reg[i]) : MAG_W'(c_reg[i]);
            h[i]        = mag_reg[i][MAG_W-1:LO_W];
            l[i]        = mag_reg[i][LO_W-1:0];
            hh_next[i]  = h[i] * h[i];
            hl_next[i]  = h[i] * l[i];
            ll_next[i]  = l[i] * l[i];
            sq_next[i]  = (SQ_W'(hh_reg[i]) << (2*LO_W)) + (SQ_W'(hl_reg[i]) << (LO_W+1))
                        + SQ_W'(ll_reg[i]);
        end
        deg5_next = (mag_reg[0] == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);
        s7_next   = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    // ---------------- restoring divide: q = floor(sq * 2^30 / s) ----------------
    always_comb begin
        logic [REM_W-1:0] r_in, r_sh;
        logic [QUO_W-1:0] q_in;
        logic [SUM_W-1:0] s_in;
        logic             bit_q;
        for (int j = 0; j < DIV_STEPS; j++) begin
            s_in = (j == 0) ? s7_reg : dv_s_reg[(j == 0) ? 0 : j-1];
            dv_s_next[j]    = s_in;
            dv_sign_next[j] = (j == 0) ? sign7_reg : dv_sign_reg[(j == 0) ? 0 : j-1];
            dv_deg_next[j]  = (j == 0) ? deg7_reg : dv_deg_reg[(j == 0) ? 0 : j-1];
            for (int i = 0; i < LANES; i++) begin
                if (j == 0) begin
                    r_in = REM_W'(sq7_reg[i]);
                    q_in = '0;
                    r_sh = r_in;
                end else begin
                    r_in = dv_r_reg[(j == 0) ? 0 : j-1][i];
                    q_in = dv_q_reg[(j == 0) ? 0 : j-1][i];
                    r_sh = r_in << 1;
                end
                bit_q = (r_sh >= REM_W'(s_in));
                dv_r_next[j][i] = bit_q ? (r_sh - REM_W'(s_in)) : r_sh;
                dv_q_next[j][i] = {q_in[QUO_W-2:0], bit_q};
            end
        end
    end

    // ---------------- digit-by-digit square root of the quotient ----------------
    always_comb begin
        logic [QUO_W-1:0]   rem_in;
        logic [ROOT_W-1:0]  root_in;
        logic [TRIAL_W-1:0] trial;
        for (int j = 0; j < SQRT_STEPS; j++) begin
            sr_sign_next[j] = (j == 0) ? dv_sign_reg[DIV_STEPS-1]
                                       : sr_sign_reg[(j == 0) ? 0 : j-1];
            sr_deg_next[j]  = (j == 0) ? dv_deg_reg[DIV_STEPS-1]
                                       : sr_deg_reg[(j == 0) ? 0 : j-1];
            for (int i = 0; i < LANES; i++) begin
                if (j == 0) begin
                    rem_in  = dv_q_reg[DIV_STEPS-1][i];
                    root_in = '0;
                end else begin
                    rem_in  = sr_rem_reg[(j == 0) ? 0 : j-1][i];
                    root_in = sr_root_reg[(j == 0) ? 0 : j-1][i];
                end
                // (root + 2^k)^2 - root^2
                trial = (TRIAL_W'(root_in) << (SQRT_STEPS - j))
                      + (TRIAL_W'(1) << (2 * (SQRT_STEPS - 1 - j)));
                if (TRIAL_W'(rem_in) >= trial) begin
                    sr_rem_next[j][i]  = QUO_W'(TRIAL_W'(rem_in) - trial);
                    sr_root_next[j][i] = root_in | (ROOT_W'(1) << (SQRT_STEPS - 1 - j));
                end else begin
                    sr_rem_next[j][i]  = rem_in;
                    sr_root_next[j][i] = root_in;
                end
            end
        end
    end

    // ---------------- rounding and sign ----------------
    always_comb begin
        logic [ROOT_W:0]   rnd;
        logic [NORM_W-1:0] m;
        for (int i = 0; i < LANES; i++) begin
            // largest odd q with q^2 <= quotient gives m = (root + 1) / 2
            rnd = {1'b0, sr_root_reg[SQRT_STEPS-1][i]} + (ROOT_W+1)'(1);
            m   = rnd[ROOT_W:1];
            if (sr_deg_reg[SQRT_STEPS-1]) begin
                fin_next.normal[i] = '0;
            end else if (sr_sign_reg[SQRT_STEPS-1][i]) begin
                fin_next.normal[i] = -m;
            end else begin
                fin_next.normal[i] = m;
            end
        end
        fin_next.degenerate = sr_deg_reg[SQRT_STEPS-1];
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            v7_reg    <= 1'b0;
            dv_v_reg  <= '0;
            sr_v_reg  <= '0;
            fin_v_reg <= 1'b0;
        end else if (en) begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
            v7_reg    <= v6_reg;
            dv_v_reg  <= {dv_v_reg[DIV_STEPS-2:0], v7_reg};
            sr_v_reg  <= {sr_v_reg[SQRT_STEPS-2:0], dv_v_reg[DIV_STEPS-1]};
            fin_v_reg <= sr_v_reg[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg        <= a_next;
            b_reg        <= b_next;
            p_reg        <= p_next;
            c_reg        <= c_next;
            mag_reg      <= mag_next;
            for (int i = 0; i < LANES; i++) begin
                sign4_reg[i] <= c_reg[i][CROSS_W-1];
            end
            sign5_reg    <= sign4_reg;
            sign6_reg    <= sign5_reg;
            sign7_reg    <= sign6_reg;
            hh_reg       <= hh_next;
            hl_reg       <= hl_next;
            ll_reg       <= ll_next;
            deg5_reg     <= deg5_next;
            deg6_reg     <= deg5_reg;
            deg7_reg     <= deg6_reg;
            sq_reg       <= sq_next;
            sq7_reg      <= sq_reg;
            s7_reg       <= s7_next;
            dv_r_reg     <= dv_r_next;
            dv_q_reg     <= dv_q_next;
            dv_s_reg     <= dv_s_next;
            dv_sign_reg  <= dv_sign_next;
            dv_deg_reg   <= dv_deg_next;
            sr_rem_reg   <= sr_rem_next;
            sr_root_reg  <= sr_root_next;
            sr_sign_reg  <= sr_sign_next;
            sr_deg_reg   <= sr_deg_next;
            fin_reg      <= fin_next;
        end
    end

    // ---------------- output register and skid ----------------
    always_comb begin
        out_v_next  = out_v_reg;
        out_next    = out_reg;
        skid_v_next = skid_v_reg;
        skid_next   = skid_reg;
        if (m_tready || !out_v_reg) begin
            if (skid_v_reg) begin
                out_v_next  = 1'b1;
                out_next    = skid_reg;
                skid_v_next = 1'b0;
            end else begin
                out_v_next = fin_v_reg;
                out_next   = fin_reg;
            end
        end else if (fin_v_reg && en) begin
            skid_v_next = 1'b1;
            skid_next   = fin_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg.normal;
    assign m_tuser  = out_reg.degenerate;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid word held with empty output register");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_v_reg) |-> $past(out_v_reg && !m_tready))
        else $error("skid filled while output was free");

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("degenerate word with nonzero normal");

    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |->
            ($signed(m_tdata[NORM_W-1:0]) <= $signed(NORM_W'(16384)))
         && ($signed(m_tdata[NORM_W-1:0]) >= $signed(-NORM_W'(16384)))
         && ($signed(m_tdata[2*NORM_W-1:NORM_W]) <= $signed(NORM_W'(16384)))
         && ($signed(m_tdata[2*NORM_W-1:NORM_W]) >= $signed(-NORM_W'(16384)))
         && ($signed(m_tdata[3*NORM_W-1:2*NORM_W]) <= $signed(NORM_W'(16384)))
         && ($signed(m_tdata[3*NORM_W-1:2*NORM_W]) >= $signed(-NORM_W'(16384))))
        else $error("normal component out of Q2.14 unit range");

endmodule

// ===== bench/face_normal_unit_top_tb.sv =====
`timescale 1ns / 1ps
module face_normal_unit_top_tb;
    import fnu_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    face_normal_unit_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    logic [IN_DATA_W-1:0] face_queue[$];
    result_t              normal_queue[$];
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   mismatches;
    int                   quiet_cycles;
    bit                   s_fire;

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // largest m <= 16384 with s*(2m-1)^2 <= mag^2 * 2^30, i.e. rounded |c|/L in Q2.14
    function automatic logic [NORM_W-1:0] unit_component(longint c, logic [127:0] s);
        logic [127:0] mag;
        logic [127:0] rhs;
        logic [127:0] odd;
        logic [127:0] lhs;
        int           lo;
        int           hi;
        int           mid;
        mag = (c < 0) ? 128'(-c) : 128'(c);
        rhs = (mag * mag) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            odd = 128'(2 * mid - 1);
            lhs = s * odd * odd;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return (c < 0) ? NORM_W'(-lo) : NORM_W'(lo);
    endfunction

    function automatic result_t face_normal(logic [IN_DATA_W-1:0] word);
        longint       v[9];
        longint       ax, ay, az, bx, by, bz;
        longint       cr[3];
        logic [127:0] s;
        logic [127:0] m;
        result_t      r;
        for (int i = 0; i < 9; i++) v[i] = longint'($signed(word[16*i +: 16]));
        ax = v[6] - v[3]; ay = v[7] - v[4]; az = v[8] - v[5];
        bx = v[3] - v[0]; by = v[4] - v[1]; bz = v[5] - v[2];
        cr[0] = ay * bz - by * az;
        cr[1] = az * bx - ax * bz;
        cr[2] = ax * by - bx * ay;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            m = (cr[i] < 0) ? 128'(-cr[i]) : 128'(cr[i]);
            s = s + m * m;
        end
        r.degenerate = (s == 0);
        for (int i = 0; i < 3; i++)
            r.normal[i] = (s == 0) ? '0 : unit_component(cr[i], s);
        return r;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_face(
        logic [15:0] x1, logic [15:0] y1, logic [15:0] z1,
        logic [15:0] x2, logic [15:0] y2, logic [15:0] z2,
        logic [15:0] x3, logic [15:0] y3, logic [15:0] z3);
        return {z3, y3, x3, z2, y2, x2, z1, y1, x1};
    endfunction

    function automatic logic [15:0] rand_coord(int kind);
        case (kind)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 15)) - 16'd8;
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(0, 1023)) - 16'd512;
        endcase
    endfunction

    // sender: takes the next word only once the current one is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (face_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= face_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= aresetn && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        result_t want;
        s_fire = aresetn && s_tvalid && s_tready;
        if (s_fire) normal_queue.push_back(face_normal(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (normal_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: normal=%h degenerate=%b", m_tdata, m_tuser);
            end else begin
                want = normal_queue.pop_front();
                if (m_tdata !== want.normal || m_tuser !== want.degenerate) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected normal=%h degenerate=%b, got %h %b",
                                 want.normal, want.degenerate, m_tdata, m_tuser);
                end
            end
        end
        if (s_fire || (m_tvalid && m_tready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int kind;
        logic [15:0] c[9];
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 62;
        mismatches    = 0;
        quiet_cycles  = 0;
        s_fire        = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // all points equal, all extremes, axis-aligned and collinear faces
        face_queue.push_back('0);
        face_queue.push_back({9{16'h7fff}});
        face_queue.push_back({9{16'h8000}});
        face_queue.push_back(pack_face(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                                       16'h8000, 16'h7fff, 16'h7fff, 16'h8000));
        face_queue.push_back(pack_face(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
                                       16'h7fff, 16'h8000, 16'h8000, 16'h7fff));
        face_queue.push_back(pack_face(16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0,
                                       16'd256, 16'd256, 16'd0));
        face_queue.push_back(pack_face(16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0,
                                       16'd256, 16'd0, 16'd256));
        face_queue.push_back(pack_face(16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0,
                                       16'd0, 16'd256, 16'd256));
        face_queue.push_back(pack_face(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd256,
                                       16'd256, 16'd0, 16'd256));
        face_queue.push_back(pack_face(16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0,
                                       16'd256, 16'd256, 16'd0));
        face_queue.push_back(pack_face(16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1,
                                       16'd2, 16'd2, 16'd2));
        face_queue.push_back(pack_face(16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd0, 16'd0,
                                       16'h7fff, 16'h7fff, 16'h7fff));
        face_queue.push_back(pack_face(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0,
                                       16'd1, 16'd1, 16'd0));
        face_queue.push_back(pack_face(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0,
                                       16'd1, 16'd1, 16'd1));
        face_queue.push_back(pack_face(16'hffff, 16'hffff, 16'hffff, 16'h5555, 16'haaaa,
                                       16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
        face_queue.push_back(pack_face(16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd5,
                                       16'd100, 16'd3, 16'd7));

        // hold the sender off until the pipe has drained
        wait (face_queue.size() == 0 && !s_tvalid && normal_queue.size() == 0);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 62 : 0;
            recv_idle_pct = (phase == 0) ? 62 : (phase == 1) ? 18 : 0;
            for (int n = 0; n < 145; n++) begin
                kind = $urandom_range(0, 3);
                for (int i = 0; i < 9; i++) c[i] = rand_coord(kind);
                // some faces with repeated or collinear points
                case ($urandom_range(0, 9))
                    0: for (int i = 0; i < 3; i++) c[3+i] = c[i];
                    1: for (int i = 0; i < 3; i++) c[6+i] = c[3+i];
                    2: for (int i = 0; i < 3; i++) c[6+i] = 16'(2 * c[3+i] - c[i]);
                    default: ;
                endcase
                face_queue.push_back(pack_face(c[0], c[1], c[2], c[3], c[4], c[5],
                                               c[6], c[7], c[8]));
            end
            wait (face_queue.size() == 0 && !s_tvalid);
        end

        wait (normal_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && normal_queue.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/fnu_pkg.sv
src/face_normal_unit_top.sv
bench/face_normal_unit_top_tb.sv
